// ----- src/dtt_pkg.sv -----
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// Request and response payloads, command and status codes, and the control
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int ITEM_BITS     = 16;
    localparam int TIME_BITS     = 48;
    localparam int ORDER_BITS    = 32;
    localparam int COUNT_BITS    = 7;
    localparam int CFG_BITS      = 32;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [CFG_BITS-1:0] IDLE_WAIT_RST = 32'd1000;
    // register index, taken from paddr[2]
    localparam logic REG_IDLE_WAIT = 1'b0;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_QUERY  = 2'd3
    } command_e;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_e;

    typedef struct packed {
        logic [1:0]           command;
        logic [ITEM_BITS-1:0] item_id;
        logic [TIME_BITS-1:0] stamp;
    } in_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [ITEM_BITS-1:0]  due_item;
        logic [TIME_BITS-1:0]  wait_ms;
        logic [COUNT_BITS-1:0] removed_count;
    } out_rsp_t;

    typedef struct packed {
        logic [ITEM_BITS-1:0]  item;
        logic [TIME_BITS-1:0]  deadline;
        logic [ORDER_BITS-1:0] order;
    } slot_t;

    typedef struct packed {
        logic load;    // capture a new request, clear scan results
        logic issue;   // read the slot at the scan index and advance
        logic commit;  // apply the request and load the response
    } ctl_cmd_t;

    typedef struct packed {
        logic last_issue;  // scan index points at the last slot
    } dp_status_t;

endpackage

// ----- src/dtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtt_ctrl: request sequencer of the deadline timer table
// Steps each request through a scan of all slots and a commit, and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module dtt_ctrl
    import dtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t sts,
    output ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load   = in_valid && in_ready;
        cmd.issue  = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_FINISH) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.last_issue)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_SCAN)
        else $error("accepted request did not start a scan");

    a_last_issue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && sts.last_issue |=> state_reg == S_DRAIN)
        else $error("scan did not end after the last slot");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("commit did not present a response");

endmodule

// ----- src/dtt_datapath.sv -----
// ----------------------------------------------------------------------------
// dtt_datapath: slot store and scan datapath of the deadline timer table
// Holds the slot memory and valid bits, compares one slot per cycle against
// the running best and free-slot search, and builds the response.
// ----------------------------------------------------------------------------
module dtt_datapath
    import dtt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_status_t          sts,
    input  in_req_t             in_data,
    input  logic [CFG_BITS-1:0] idle_wait,
    output out_rsp_t            out_data
);

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    slot_t slot_mem [ENTRIES];

    in_req_t               req_reg;
    logic [IDX_BITS-1:0]   scan_idx_reg;
    logic                  rd_live_reg;
    logic [IDX_BITS-1:0]   rd_idx_reg;
    slot_t                 rd_slot_reg;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic                  free_found_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;
    logic                  best_found_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;
    logic [TIME_BITS-1:0]  best_deadline_reg;
    logic [ORDER_BITS-1:0] best_order_reg;
    logic [ITEM_BITS-1:0]  best_item_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [ORDER_BITS-1:0] order_ctr_reg;
    out_rsp_t              rsp_reg, rsp_next;

    logic                  rd_valid;
    logic                  cand;
    logic [ORDER_BITS-1:0] order_diff;
    logic                  cand_first;
    logic                  item_hit;
    logic                  remove_hit;
    logic                  pop_ok;
    logic                  mem_we;
    slot_t                 new_slot;

    assign sts.last_issue = (scan_idx_reg == IDX_BITS'(ENTRIES - 1));
    assign out_data       = rsp_reg;

    // compare stage: slot rd_idx_reg against the running results
    assign rd_valid   = valid_reg[rd_idx_reg];
    assign cand       = rd_live_reg && rd_valid;
    assign order_diff = rd_slot_reg.order - best_order_reg;
    assign cand_first = !best_found_reg ||
                        ((rd_slot_reg.deadline != best_deadline_reg) ?
                         (rd_slot_reg.deadline < best_deadline_reg) :
                         order_diff[ORDER_BITS-1]);
    assign item_hit   = (rd_slot_reg.item == req_reg.item_id);
    assign remove_hit = cand && (req_reg.command == CMD_REMOVE) && item_hit;

    assign pop_ok   = best_found_reg && (best_deadline_reg <= req_reg.stamp);
    assign mem_we   = cmd.commit && (req_reg.command == CMD_ADD) && free_found_reg;

    always_comb
    begin
        new_slot.item     = req_reg.item_id;
        new_slot.deadline = req_reg.stamp;
        new_slot.order    = order_ctr_reg;
    end

    // one write port for add, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[free_idx_reg] <= new_slot;
        rd_slot_reg <= slot_mem[scan_idx_reg];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (remove_hit)
            valid_next[rd_idx_reg] = 1'b0;
        if (mem_we)
            valid_next[free_idx_reg] = 1'b1;
        if (cmd.commit && (req_reg.command == CMD_POP) && pop_ok)
            valid_next[best_idx_reg] = 1'b0;
    end

    always_comb
    begin
        rsp_next = '0;
        case (req_reg.command)
            CMD_ADD:
                rsp_next.status = free_found_reg ? ST_DONE : ST_FULL;
            CMD_POP:
            begin
                if (pop_ok)
                begin
                    rsp_next.status   = ST_DONE;
                    rsp_next.due_item = best_item_reg;
                end
                else
                    rsp_next.status = ST_NONE;
            end
            CMD_REMOVE:
            begin
                rsp_next.status        = ST_DONE;
                rsp_next.removed_count = COUNT_BITS'(count_reg);
            end
            CMD_QUERY:
            begin
                if (!best_found_reg)
                begin
                    rsp_next.status  = ST_NONE;
                    rsp_next.wait_ms = TIME_BITS'(idle_wait);
                end
                else
                begin
                    rsp_next.status = ST_DONE;
                    if (best_deadline_reg > req_reg.stamp)
                        rsp_next.wait_ms = best_deadline_reg - req_reg.stamp;
                end
            end
            default:
                rsp_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            rd_live_reg    <= 1'b0;
            valid_reg      <= '0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            order_ctr_reg  <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            rd_live_reg <= cmd.issue;
            if (cmd.load)
                scan_idx_reg <= '0;
            else if (cmd.issue && !sts.last_issue)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmd.load)
            begin
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (rd_live_reg && !rd_valid && !free_found_reg)
                    free_found_reg <= 1'b1;
                if (cand && cand_first)
                    best_found_reg <= 1'b1;
            end
            if (mem_we)
                order_ctr_reg <= order_ctr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        if (cmd.load)
        begin
            req_reg   <= in_data;
            count_reg <= '0;
        end
        else if (remove_hit)
            count_reg <= count_reg + 1'b1;
        if (rd_live_reg && !rd_valid && !free_found_reg)
            free_idx_reg <= rd_idx_reg;
        if (cand && cand_first)
        begin
            best_idx_reg      <= rd_idx_reg;
            best_deadline_reg <= rd_slot_reg.deadline;
            best_order_reg    <= rd_slot_reg.order;
            best_item_reg     <= rd_slot_reg.item;
        end
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(free_idx_reg)])
        else $error("added slot not marked valid");

    a_pop_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (req_reg.command == CMD_POP) && pop_ok
        |=> !valid_reg[$past(best_idx_reg)])
        else $error("popped slot still valid");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (req_reg.command == CMD_REMOVE)
        |-> count_reg <= CNT_BITS'(ENTRIES))
        else $error("remove count exceeds table size");

endmodule

// ----- src/deadline_timer_table.sv -----
// ----------------------------------------------------------------------------
// deadline_timer_table: table of pending timers ordered by deadline
// Add, pop-expired, remove-by-item and query-wait on up to ENTRIES timers,
// with an APB register for the idle wait.
// ----------------------------------------------------------------------------
// Each request (add, pop expired, remove item, query wait) runs one pass over
// all ENTRIES slots through the single read port of the slot memory, one slot
// per cycle. A request is taken in the idle state, then the slots are read in
// the scan state, the last compare finishes in the drain state and the result
// is committed in the finish state. The block returns to idle as the response
// becomes valid, so the next request can be taken while it is held; the commit
// waits while an earlier response is still held in the output register.
// The pass finds the lowest free slot for add, the earliest timer for pop and
// query (smallest deadline, then the oldest insertion stamp), and clears every
// matching slot for remove. Responses sit in an output register, so a new
// request is taken while the previous response waits for out_ready. Valid bits
// reset to empty; no clearing pass is needed. Write idle_wait (byte address 0)
// only while the table has no request in flight.
module deadline_timer_table
    import dtt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_req_t                  in_data,
    // response channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_rsp_t                 out_data,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_BITS-1:0]      pwdata,
    output logic [CFG_BITS-1:0]      prdata,
    output logic                     pready
);

    ctl_cmd_t            cmd;
    dp_status_t          sts;
    logic [CFG_BITS-1:0] idle_wait_reg;
    logic                cfg_sel;

    // only paddr[2] is decoded: idle wait when it is clear, zero when it is set
    assign cfg_sel = (paddr[2] == REG_IDLE_WAIT);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? idle_wait_reg : '0;

    // hold idle wait; load it on the access phase of a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_wait_reg <= IDLE_WAIT_RST;
        else if (psel && penable && pwrite && pready && cfg_sel)
            idle_wait_reg <= pwdata;
    end

    // sequence each request: take, scan, drain, commit
    dtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot memory, valid bits, compare and response register
    dtt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .idle_wait (idle_wait_reg),
        .out_data  (out_data)
    );

endmodule
